[hw/rtl/lgs_pkg.sv]
package lgs_pkg;

    localparam int LGS_GRID_WIDTH  = 32;
    localparam int LGS_GRID_HEIGHT = 32;

    // row indexes in the command carry enough bits for the tallest grid
    localparam int LGS_ROW_IDX_W = 8;

    localparam logic [3:0] LGS_BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] LGS_SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_TOGGLE  = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef struct packed {
        logic                     capture;
        logic                     clr;
        logic                     rd_en;
        logic                     rd_sweep;
        logic [LGS_ROW_IDX_W-1:0] rd_row;
        logic                     wr_gen;
        logic                     wr_tgl;
        logic [LGS_ROW_IDX_W-1:0] wr_row;
        logic                     shift;
        logic                     out_load;
    } t_dp_cmd;

endpackage

[hw/rtl/lgs_in_if.sv]
interface lgs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] column;
    logic [4:0] row;

    modport source (output valid, output action, output column, output row, input ready);
    modport sink   (input valid, input action, input column, input row, output ready);
endinterface

[hw/rtl/lgs_out_if.sv]
interface lgs_out_if;
    logic valid;
    logic ready;
    logic cell_alive;

    modport source (output valid, output cell_alive, input ready);
    modport sink   (input valid, input cell_alive, output ready);
endinterface

[hw/rtl/lgs_datapath.sv]
module lgs_datapath #(
    parameter int GRID_WIDTH  = lgs_pkg::LGS_GRID_WIDTH,
    parameter int GRID_HEIGHT = lgs_pkg::LGS_GRID_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lgs_pkg::t_dp_cmd i_cmd,
    input  logic [4:0]      i_column,
    input  logic [4:0]      i_row,
    output logic            o_cell_alive
);

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);

    logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_row_vld;

    logic [4:0]            r_col;
    logic [4:0]            r_row;
    logic [GRID_WIDTH-1:0] r_rdata;
    logic [GRID_WIDTH-1:0] r_prev;
    logic [GRID_WIDTH-1:0] r_cur;
    logic                  r_cell_alive;

    logic                  in_grid;
    logic [COL_W-1:0]      col_idx;
    logic [ROW_W-1:0]      cell_row;
    logic [ROW_W-1:0]      rd_addr;
    logic [ROW_W-1:0]      wr_addr;
    logic                  wr_en;
    logic [GRID_WIDTH-1:0] wr_data;
    logic [GRID_WIDTH-1:0] gen_row;
    logic [GRID_WIDTH-1:0] tgl_mask;

    assign in_grid  = (32'(r_col) < GRID_WIDTH) && (32'(r_row) < GRID_HEIGHT);
    assign col_idx  = COL_W'(r_col);
    assign cell_row = ROW_W'(r_row);
    assign tgl_mask = GRID_WIDTH'(1) << col_idx;

    assign rd_addr = i_cmd.rd_sweep ? i_cmd.rd_row[ROW_W-1:0] : cell_row;
    assign wr_en   = i_cmd.wr_gen || (i_cmd.wr_tgl && in_grid);
    assign wr_addr = i_cmd.wr_gen ? i_cmd.wr_row[ROW_W-1:0] : cell_row;
    assign wr_data = i_cmd.wr_gen ? gen_row : (r_rdata ^ tgl_mask);

    // window: r_prev and r_cur hold the two rows above the one in r_rdata
    always_comb begin
        logic [3:0] cnt;
        cnt     = '0;
        gen_row = r_cur;
        for (int c = 1; c < GRID_WIDTH - 1; c++) begin
            cnt = 4'(r_prev[c-1]) + 4'(r_prev[c]) + 4'(r_prev[c+1])
                + 4'(r_cur[c-1]) + 4'(r_cur[c+1])
                + 4'(r_rdata[c-1]) + 4'(r_rdata[c]) + 4'(r_rdata[c+1]);
            gen_row[c] = (cnt == lgs_pkg::LGS_BIRTH_COUNT)
                      || (r_cur[c] && cnt == lgs_pkg::LGS_SURVIVE_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // rows never written since reset or the last clear read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_row_vld[rd_addr] ? mem[rd_addr] : '0;
        end
        if (i_cmd.capture) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (i_cmd.shift) begin
            r_prev <= r_cur;
            r_cur  <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_cell_alive <= in_grid && r_rdata[col_idx];
        end
    end

    assign o_cell_alive = r_cell_alive;

endmodule

[hw/rtl/lgs_ctrl.sv]
module lgs_ctrl #(
    parameter int GRID_WIDTH  = lgs_pkg::LGS_GRID_WIDTH,
    parameter int GRID_HEIGHT = lgs_pkg::LGS_GRID_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_action,
    output logic             o_in_ready,
    output lgs_pkg::t_dp_cmd o_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready
);

    localparam int ROW_W = $clog2(GRID_HEIGHT);
    localparam int CNT_W = $clog2(GRID_HEIGHT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TGL_RD,
        ST_TGL_WR,
        ST_GEN,
        ST_FIN_RD,
        ST_FIN_WAIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_idx;
    logic [ROW_W-1:0] r_didx;
    logic             r_dv;
    logic             r_out_valid;

    logic             accept;
    logic             sweep_rd;
    logic             out_free;
    lgs_pkg::t_action action;

    assign action   = lgs_pkg::t_action'(i_action);
    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign sweep_rd = (r_state == ST_GEN) && (r_idx < CNT_W'(GRID_HEIGHT));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.rd_row   = lgs_pkg::LGS_ROW_IDX_W'(r_idx);
        o_cmd.wr_row   = lgs_pkg::LGS_ROW_IDX_W'(r_didx - ROW_W'(1));
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            ST_TGL_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_TGL_WR: begin
                o_cmd.wr_tgl = 1'b1;
            end
            ST_GEN: begin
                o_cmd.rd_en    = sweep_rd;
                o_cmd.rd_sweep = 1'b1;
                o_cmd.shift    = r_dv;
                o_cmd.wr_gen   = r_dv && (r_didx >= ROW_W'(2));
            end
            ST_FIN_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_FIN_WAIT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_didx      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    r_dv  <= 1'b0;
                    if (accept) begin
                        unique case (action)
                            lgs_pkg::ACT_CLEAR:   r_state <= ST_CLEAR;
                            lgs_pkg::ACT_TOGGLE:  r_state <= ST_TGL_RD;
                            lgs_pkg::ACT_ADVANCE: r_state <= ST_GEN;
                            lgs_pkg::ACT_READ:    r_state <= ST_FIN_RD;
                            default:              r_state <= ST_FIN_RD;
                        endcase
                    end
                end
                ST_CLEAR:  r_state <= ST_FIN_RD;
                ST_TGL_RD: r_state <= ST_TGL_WR;
                ST_TGL_WR: r_state <= ST_FIN_RD;
                ST_GEN: begin
                    // read data arrives in the cycle after its read address
                    r_dv   <= sweep_rd;
                    r_didx <= ROW_W'(r_idx);
                    if (sweep_rd) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_dv && r_didx == ROW_W'(GRID_HEIGHT - 1)) begin
                        r_state <= ST_FIN_RD;
                    end
                end
                ST_FIN_RD: r_state <= ST_FIN_WAIT;
                ST_FIN_WAIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input taken again right after an accept");

    a_gen_row_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_gen |-> (o_cmd.wr_row >= lgs_pkg::LGS_ROW_IDX_W'(1)
            && o_cmd.wr_row <= lgs_pkg::LGS_ROW_IDX_W'(GRID_HEIGHT - 2)))
        else $error("generation wrote a border row");

    a_clr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr |-> !(o_cmd.wr_gen || o_cmd.wr_tgl))
        else $error("clear collides with a row write");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a word not yet taken");

    a_gen_exits_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN) ##1 (r_state == ST_FIN_RD)
            |-> $past(r_didx) == ROW_W'(GRID_HEIGHT - 1))
        else $error("sweep ended before the last row");

endmodule

[hw/rtl/life_grid_generation_step_core.sv]
// channel  | dir | handshake     | word
// i_req    | in  | valid / ready | action[1:0], column[4:0], row[4:0]
// o_rsp    | out | valid / ready | cell_alive
//
// one word in flight: clear, toggle and read each end in ST_FIN_RD then ST_FIN_WAIT, which loads the result
// advance: the row memory, with separate read and write addresses, is swept one row
// per cycle through a three-row window, writing each new interior row in place
// reset clears the per-row valid bits at once, so the grid reads dead with no fill pass
// a result held on o_rsp blocks only the next word's final load, not its acceptance
module life_grid_generation_step_core #(
    parameter int GRID_WIDTH  = lgs_pkg::LGS_GRID_WIDTH,
    parameter int GRID_HEIGHT = lgs_pkg::LGS_GRID_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lgs_in_if.sink    i_req,
    lgs_out_if.source o_rsp
);

    lgs_pkg::t_dp_cmd cmd;

    lgs_ctrl #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.action),
        .o_in_ready  (i_req.ready),
        .o_cmd       (cmd),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready)
    );

    lgs_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_column     (i_req.column),
        .i_row        (i_req.row),
        .o_cell_alive (o_rsp.cell_alive)
    );

endmodule

[tb/life_grid_generation_step_core_test.sv]
module life_grid_generation_step_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W       = lgs_pkg::LGS_GRID_WIDTH;
    localparam int GRID_H       = lgs_pkg::LGS_GRID_HEIGHT;
    localparam int SETTLE_TICKS = GRID_H + 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 1600;

    typedef struct packed {
        lgs_pkg::t_action action;
        logic [4:0]       column;
        logic [4:0]       row;
    } t_cell_cmd;

    logic i_clk;
    logic i_rst_n;

    lgs_in_if  req_if ();
    lgs_out_if rsp_if ();

    life_grid_generation_step_core #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // predicted grid, bit c of row r is the cell at column c
    logic [GRID_W-1:0] life_grid [GRID_H];

    t_cell_cmd cmd_backlog [$];
    logic      expected_alive [$];
    int        cmds_queued;
    int        mismatches;
    int        send_idle_pct;
    int        rsp_stall_pct;
    int        quiet_cycles;
    t_cell_cmd next_cmd;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int live_neighbors(const ref logic [GRID_W-1:0] g [GRID_H],
                                          input int r, input int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0)
                    n += g[r + dr][c + dc];
        return n;
    endfunction

    function automatic void advance_life_grid();
        logic [GRID_W-1:0] prev [GRID_H];
        int n;
        prev = life_grid;
        for (int r = 1; r < GRID_H - 1; r++) begin
            for (int c = 1; c < GRID_W - 1; c++) begin
                n = live_neighbors(prev, r, c);
                life_grid[r][c] = (n == int'(lgs_pkg::LGS_BIRTH_COUNT)) ||
                                  (prev[r][c] && n == int'(lgs_pkg::LGS_SURVIVE_COUNT));
            end
        end
    endfunction

    // updates the predicted grid and returns the addressed cell afterwards
    function automatic logic apply_cell_cmd(t_cell_cmd cmd);
        logic on_grid;
        on_grid = (int'(cmd.column) < GRID_W) && (int'(cmd.row) < GRID_H);
        case (cmd.action)
            lgs_pkg::ACT_CLEAR: begin
                foreach (life_grid[r]) life_grid[r] = '0;
            end
            lgs_pkg::ACT_TOGGLE: begin
                if (on_grid)
                    life_grid[cmd.row][cmd.column] = ~life_grid[cmd.row][cmd.column];
            end
            lgs_pkg::ACT_ADVANCE: begin
                advance_life_grid();
            end
            default: ;
        endcase
        return on_grid ? life_grid[cmd.row][cmd.column] : 1'b0;
    endfunction

    task automatic queue_cmd(lgs_pkg::t_action act, int col, int row);
        t_cell_cmd cmd;
        cmd.action = act;
        cmd.column = 5'(col);
        cmd.row    = 5'(row);
        cmd_backlog.push_back(cmd);
        cmds_queued++;
    endtask

    task automatic queue_noise_cmd();
        queue_cmd(lgs_pkg::t_action'(2'($urandom_range(3))),
                  $urandom_range(31), $urandom_range(31));
    endtask

    // clear, seed a window with random cells, then let it evolve and probe it
    task automatic queue_pattern_run();
        int span, ox, oy, seeds, gens;
        span  = ($urandom_range(5) == 0) ? $urandom_range(16, GRID_W) : $urandom_range(3, 8);
        ox    = $urandom_range(0, GRID_W - span);
        oy    = $urandom_range(0, GRID_H - span);
        seeds = $urandom_range(span / 2 + 1, (span * span) / 3 + 2);
        gens  = $urandom_range(1, 6);
        queue_cmd(lgs_pkg::ACT_CLEAR, $urandom_range(31), $urandom_range(31));
        repeat (seeds)
            queue_cmd(lgs_pkg::ACT_TOGGLE, ox + $urandom_range(span - 1),
                      oy + $urandom_range(span - 1));
        repeat (gens) begin
            queue_cmd(lgs_pkg::ACT_ADVANCE, ox + $urandom_range(span - 1),
                      oy + $urandom_range(span - 1));
            repeat ($urandom_range(0, 3))
                queue_cmd(lgs_pkg::ACT_READ, ox + $urandom_range(span - 1),
                          oy + $urandom_range(span - 1));
            if ($urandom_range(4) == 0)
                queue_cmd(lgs_pkg::ACT_TOGGLE, ox + $urandom_range(span - 1),
                          oy + $urandom_range(span - 1));
        end
    endtask

    task automatic drain_all();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || req_if.valid || expected_alive.size() != 0);
    endtask

    // word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_alive.push_back(apply_cell_cmd({lgs_pkg::t_action'(req_if.action),
                                                         req_if.column, req_if.row}));
            end
            if (!req_if.valid || req_if.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd       = cmd_backlog.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.action <= next_cmd.action;
                    req_if.column <= next_cmd.column;
                    req_if.row    <= next_cmd.row;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_alive.size() == 0) begin
                    $error("cell_alive: result word with nothing expected, got %0b",
                           rsp_if.cell_alive);
                    mismatches++;
                end else if (rsp_if.cell_alive !== expected_alive[0]) begin
                    $error("cell_alive: expected %0b, got %0b",
                           expected_alive[0], rsp_if.cell_alive);
                    mismatches++;
                    void'(expected_alive.pop_front());
                end else begin
                    void'(expected_alive.pop_front());
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int send_pct [4];
        int stall_pct [4];
        send_pct  = '{0, 88, 0, 18};
        stall_pct = '{0, 0, 88, 18};

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = lgs_pkg::ACT_READ;
        req_if.column = '0;
        req_if.row    = '0;
        rsp_if.ready  = 1'b0;
        cmds_queued   = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        foreach (life_grid[r]) life_grid[r] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners and border rows stay put across a generation
        queue_cmd(lgs_pkg::ACT_READ, 0, 0);
        queue_cmd(lgs_pkg::ACT_TOGGLE, 0, 0);
        queue_cmd(lgs_pkg::ACT_TOGGLE, GRID_W - 1, GRID_H - 1);
        queue_cmd(lgs_pkg::ACT_TOGGLE, GRID_W - 1, 0);
        queue_cmd(lgs_pkg::ACT_TOGGLE, 0, GRID_H - 1);
        // three live border neighbors give a birth just inside the corner
        queue_cmd(lgs_pkg::ACT_TOGGLE, 1, 0);
        queue_cmd(lgs_pkg::ACT_TOGGLE, 2, 0);
        // blinker in the interior
        queue_cmd(lgs_pkg::ACT_TOGGLE, 5, 4);
        queue_cmd(lgs_pkg::ACT_TOGGLE, 5, 5);
        queue_cmd(lgs_pkg::ACT_TOGGLE, 5, 6);
        queue_cmd(lgs_pkg::ACT_ADVANCE, 1, 1);
        queue_cmd(lgs_pkg::ACT_READ, 5, 5);
        queue_cmd(lgs_pkg::ACT_READ, 4, 5);
        queue_cmd(lgs_pkg::ACT_READ, 5, 4);
        queue_cmd(lgs_pkg::ACT_ADVANCE, 0, 0);
        queue_cmd(lgs_pkg::ACT_READ, GRID_W - 1, GRID_H - 1);
        queue_cmd(lgs_pkg::ACT_TOGGLE, GRID_W - 1, GRID_H - 1);
        queue_cmd(lgs_pkg::ACT_CLEAR, 5, 5);
        queue_cmd(lgs_pkg::ACT_READ, 0, GRID_H - 1);
        drain_all();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct[p];
            rsp_stall_pct = stall_pct[p];
            cmds_queued   = 0;
            while (cmds_queued < RANDOM_WORDS / 4) begin
                if ($urandom_range(9) < 8)
                    queue_pattern_run();
                else
                    repeat ($urandom_range(1, 6)) queue_noise_cmd();
            end
            // sender holds off until every result is back
            drain_all();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0 && expected_alive.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[life_grid_generation_step_core.f]
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_in_if.sv
hw/rtl/lgs_out_if.sv
hw/rtl/lgs_datapath.sv
hw/rtl/lgs_ctrl.sv
hw/rtl/life_grid_generation_step_core.sv
tb/life_grid_generation_step_core_test.sv
